// ===== rtl/text_console_char_writer_defines.svh =====
// assertion macros used by the checker file
`ifndef TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH

// property checked on every rising edge of clk, off while rst_n is low
`define TCCW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("console checker: property failed");

// property checked on every rising edge of clk, reset included
`define TCCW_ASSERT_ANY(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("console checker: reset property failed");

`endif

// ===== rtl/tccw_pkg.sv =====
`timescale 1ns / 1ps

package tccw_pkg;

  // one input transfer
  typedef struct packed {
    logic       opcode;
    logic [7:0] char_code;
    logic [6:0] read_column;
    logic [4:0] read_row;
  } in_t;

  // one result transfer
  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
    logic        scrolled;
  } out_t;

  // operation codes
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // special characters and reset values
  localparam logic [7:0]  CHAR_TAB     = 8'd9;
  localparam logic [7:0]  CHAR_NEWLINE = 8'd10;
  localparam logic [7:0]  CHAR_SPACE   = 8'd32;
  localparam logic [7:0]  RESET_COLOR  = 8'h07;
  localparam logic [15:0] RESET_CELL   = {RESET_COLOR, CHAR_SPACE};

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic put;
    logic newline;
    logic cnt_clr;
    logic copy;
    logic blank;
    logic fill;
    logic emit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic in_read;
    logic in_newline;
    logic wraps_last;
    logic row_last;
    logic count_last;
    logic count_zero;
    logic copy_done;
    logic fill_done;
  } sts_t;

endpackage

// ===== rtl/tccw_ctrl.sv =====
`timescale 1ns / 1ps

module tccw_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  tccw_pkg::sts_t sts,
  output logic           busy,
  output tccw_pkg::cmd_t cmd
);

  typedef enum logic [6:0] {
    ST_CLEAR   = 7'b0000001,
    ST_IDLE    = 7'b0000010,
    ST_READ    = 7'b0000100,
    ST_NEWLINE = 7'b0001000,
    ST_PUT     = 7'b0010000,
    ST_COPY    = 7'b0100000,
    ST_BLANK   = 7'b1000000
  } state_t;

  state_t st_r, st_nxt;

  // state register, reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR;
    end else begin
      st_r <= st_nxt;
    end
  end

  // next state and commands
  always_comb begin
    st_nxt = st_r;
    cmd    = '0;
    unique case (st_r)
      ST_CLEAR: begin
        cmd.fill = 1'b1;
        if (sts.fill_done) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (sts.in_read)         st_nxt = ST_READ;
          else if (sts.in_newline) st_nxt = ST_NEWLINE;
          else                     st_nxt = ST_PUT;
        end
      end
      ST_READ: begin
        cmd.emit = 1'b1;
        st_nxt   = ST_IDLE;
      end
      ST_NEWLINE: begin
        cmd.newline = 1'b1;
        if (sts.row_last) begin
          cmd.cnt_clr = 1'b1;
          st_nxt      = ST_COPY;
        end else begin
          cmd.emit = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      ST_PUT: begin
        cmd.put = 1'b1;
        if (sts.wraps_last) begin
          cmd.cnt_clr = 1'b1;
          st_nxt      = ST_COPY;
        end else if (sts.count_last) begin
          cmd.emit = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      ST_COPY: begin
        cmd.copy = 1'b1;
        if (sts.copy_done) st_nxt = ST_BLANK;
      end
      ST_BLANK: begin
        cmd.blank = 1'b1;
        if (sts.fill_done) begin
          if (sts.count_zero) begin
            cmd.emit = 1'b1;
            st_nxt   = ST_IDLE;
          end else begin
            st_nxt = ST_PUT;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign busy = (st_r != ST_IDLE);

endmodule

// ===== rtl/tccw_datapath.sv =====
`timescale 1ns / 1ps

module tccw_datapath #(
  parameter int COLUMNS    = 80,
  parameter int ROWS       = 25,
  parameter int TAB_SPACES = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  tccw_pkg::in_t  in_data,
  input  logic           cfg_we,
  input  logic [7:0]     cfg_wdata,
  input  tccw_pkg::cmd_t cmd,
  output tccw_pkg::sts_t sts,
  output logic           out_valid,
  output tccw_pkg::out_t out_data
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(TAB_SPACES + 1);

  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_END  = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);
  localparam logic [6:0]    LAST_COL  = 7'(COLUMNS - 1);
  localparam logic [4:0]    LAST_ROW  = 5'(ROWS - 1);
  localparam logic [CW-1:0] TAB_CNT   = CW'(TAB_SPACES);
  localparam logic [CW-1:0] ONE_CNT   = CW'(1);

  logic [15:0]   mem [CELLS];
  logic [15:0]   rdata_r;
  logic [7:0]    text_color_r;
  logic [4:0]    row_r, row_nxt;
  logic [6:0]    col_r, col_nxt;
  logic          scrolled_r, scrolled_nxt;
  logic [CW-1:0] cnt_r;
  logic [7:0]    ch_r;
  logic          op_r;
  logic          rd_ok_r;
  logic [AW-1:0] s_r;
  logic          out_valid_r;
  tccw_pkg::out_t out_data_r;

  logic [11:0]   in_lin, cur_lin;
  logic [AW-1:0] raddr, waddr;
  logic [15:0]   wdata;
  logic          we;
  logic          in_tab;

  // linear addresses of the requested cell and the cursor
  assign in_lin  = 12'(in_data.read_row) * 12'(COLUMNS) + 12'(in_data.read_column);
  assign cur_lin = 12'(row_r) * 12'(COLUMNS) + 12'(col_r);
  assign in_tab  = (in_data.char_code == tccw_pkg::CHAR_TAB);

  // read port: scroll source row or the requested cell
  always_comb begin
    if (cmd.copy) begin
      raddr = sts.copy_done ? s_r : s_r + ROW_STEP;
    end else begin
      raddr = in_lin[AW-1:0];
    end
  end

  // write port select
  always_comb begin
    we    = 1'b0;
    waddr = s_r;
    wdata = tccw_pkg::RESET_CELL;
    priority if (cmd.fill) begin
      we = 1'b1;
    end else if (cmd.blank) begin
      we    = 1'b1;
      wdata = {text_color_r, tccw_pkg::CHAR_SPACE};
    end else if (cmd.copy) begin
      we    = (s_r != '0);
      waddr = s_r - AW'(1);
      wdata = rdata_r;
    end else if (cmd.put) begin
      we    = 1'b1;
      waddr = cur_lin[AW-1:0];
      wdata = {text_color_r, ch_r};
    end
  end

  // screen store
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  // cursor and scroll flag next values
  always_comb begin
    row_nxt      = row_r;
    col_nxt      = col_r;
    scrolled_nxt = scrolled_r;
    if (cmd.accept) scrolled_nxt = 1'b0;
    if (cmd.put) begin
      if (col_r == LAST_COL) begin
        col_nxt = '0;
        if (row_r == LAST_ROW) scrolled_nxt = 1'b1;
        else                   row_nxt = row_r + 5'd1;
      end else begin
        col_nxt = col_r + 7'd1;
      end
    end else if (cmd.newline) begin
      col_nxt = '0;
      if (row_r == LAST_ROW) scrolled_nxt = 1'b1;
      else                   row_nxt = row_r + 5'd1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= tccw_pkg::RESET_COLOR;
      row_r        <= '0;
      col_r        <= '0;
      s_r          <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) text_color_r <= cfg_wdata;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      out_valid_r <= cmd.emit;
      if (cmd.cnt_clr) begin
        s_r <= '0;
      end else if (cmd.fill || cmd.blank || (cmd.copy && !sts.copy_done)) begin
        s_r <= s_r + AW'(1);
      end
    end
  end

  // per item registers, loaded on transfer
  always_ff @(posedge clk) begin
    scrolled_r <= scrolled_nxt;
    if (cmd.accept) begin
      op_r    <= in_data.opcode;
      ch_r    <= in_tab ? tccw_pkg::CHAR_SPACE : in_data.char_code;
      rd_ok_r <= (in_data.read_column <= LAST_COL) && (in_data.read_row <= LAST_ROW);
      if (in_data.opcode == tccw_pkg::OP_READ ||
          in_data.char_code == tccw_pkg::CHAR_NEWLINE) begin
        cnt_r <= '0;
      end else if (in_tab) begin
        cnt_r <= TAB_CNT;
      end else begin
        cnt_r <= ONE_CNT;
      end
    end else if (cmd.put) begin
      cnt_r <= cnt_r - ONE_CNT;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.cell_value    <= (op_r == tccw_pkg::OP_READ && rd_ok_r) ? rdata_r : '0;
      out_data_r.cursor_row    <= row_nxt;
      out_data_r.cursor_column <= col_nxt;
      out_data_r.scrolled      <= scrolled_nxt;
    end
  end

  // status to the controller
  always_comb begin
    sts.in_read    = (in_data.opcode == tccw_pkg::OP_READ);
    sts.in_newline = (in_data.char_code == tccw_pkg::CHAR_NEWLINE);
    sts.wraps_last = (col_r == LAST_COL) && (row_r == LAST_ROW);
    sts.row_last   = (row_r == LAST_ROW);
    sts.count_last = (cnt_r == ONE_CNT);
    sts.count_zero = (cnt_r == '0);
    sts.copy_done  = (s_r == COPY_END);
    sts.fill_done  = (s_r == LAST_CELL);
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/text_console_char_writer.sv =====
`timescale 1ns / 1ps

// Text console character writer: a ROWS x COLUMNS screen store of 16-bit
// cells (character low byte, attribute high byte) and a cursor.
// Input: an item transfers at a clock edge with start high and busy low;
// in_data carries opcode, char_code, read_column and read_row.
// Result: exactly one per item, on out_data for one cycle with out_valid
// high. The receiver cannot stall; results are never held back.
// Config: cfg_we with cfg_wdata writes the attribute used for new cells.
// Sequencing, set by the screen memory (one read and one write per
// cycle) and the sequencer; a new item is taken only once idle again:
//   read           READ state, then the result register
//   ordinary char  PUT state, newline NEWLINE state
//   tab            PUT state repeated for each of the TAB_SPACES spaces
//   each scroll    adds the COPY and BLANK passes (one cell moved per cycle)
// Reset: cursor to 0,0, attribute to 7, then a clearing pass over all
// ROWS*COLUMNS cells fills the store with grey spaces; busy stays high
// until it ends. Config writes are taken during that pass.

module text_console_char_writer #(
  parameter int COLUMNS    = 80,
  parameter int ROWS       = 25,
  parameter int TAB_SPACES = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  tccw_pkg::in_t  in_data,
  output logic           out_valid,
  output tccw_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [7:0]     cfg_wdata
);

  tccw_pkg::cmd_t cmd;
  tccw_pkg::sts_t sts;

  // sequencer
  tccw_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  // screen store, cursor and result registers
  tccw_datapath #(
    .COLUMNS    (COLUMNS),
    .ROWS       (ROWS),
    .TAB_SPACES (TAB_SPACES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/tccw_checker.sv =====
`timescale 1ns / 1ps
`include "text_console_char_writer_defines.svh"

module tccw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input tccw_pkg::out_t out_data
);

  // reset always starts the clearing pass
  `TCCW_ASSERT_ANY(a_reset_busy, !rst_n |=> busy)

  // every transfer makes the block busy in the next cycle
  `TCCW_ASSERT(a_accept_busy, (start && !busy) |=> busy)

  // a result shows while the block is ready again, and never twice in a row
  `TCCW_ASSERT(a_result_idle, out_valid |-> (!busy ##1 !out_valid))

  // reported cursor stays on the screen
  `TCCW_ASSERT(a_cursor_range, out_valid |->
    (out_data.cursor_row < ROWS && out_data.cursor_column < COLUMNS))

endmodule

bind text_console_char_writer tccw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tccw_checker (.*);

// ===== dv/text_console_char_writer_tb.sv =====
`timescale 1ns / 1ps

module text_console_char_writer_tb;

  localparam int SCREEN_COLS  = 80;
  localparam int SCREEN_ROWS  = 25;
  localparam int TAB_WIDTH    = 4;
  localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;
  localparam int DRAIN_LIMIT  = 10000;
  localparam int CYCLE_LIMIT  = 12000000;
  localparam int PHASE_ITEMS  = 200;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  tccw_pkg::in_t  in_data;
  logic out_valid;
  tccw_pkg::out_t out_data;
  logic cfg_we;
  logic [7:0] cfg_wdata;

  // shadow copy of the console state
  logic [15:0] screen_model [SCREEN_CELLS];
  int          cursor_row_model;
  int          cursor_col_model;
  logic [7:0]  color_model;

  tccw_pkg::out_t console_results_due[$];
  int   fail_count = 0;
  int   cycle_count = 0;
  bit   idle_enabled;

  text_console_char_writer #(
    .COLUMNS   (SCREEN_COLS),
    .ROWS      (SCREEN_ROWS),
    .TAB_SPACES(TAB_WIDTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // screen scroll: rows move up one, last row blanked in the current color
  function automatic void scroll_model();
    for (int i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++)
      screen_model[i] = screen_model[i + SCREEN_COLS];
    for (int i = SCREEN_CELLS - SCREEN_COLS; i < SCREEN_CELLS; i++)
      screen_model[i] = {color_model, tccw_pkg::CHAR_SPACE};
  endfunction

  // cursor down one row, scrolling at the bottom
  function automatic bit model_next_row();
    if (cursor_row_model == SCREEN_ROWS - 1) begin
      scroll_model();
      return 1'b1;
    end
    cursor_row_model++;
    return 1'b0;
  endfunction

  // write one glyph at the cursor and advance with wrap
  function automatic bit model_put(logic [7:0] ch);
    screen_model[cursor_row_model * SCREEN_COLS + cursor_col_model] = {color_model, ch};
    if (cursor_col_model == SCREEN_COLS - 1) begin
      cursor_col_model = 0;
      return model_next_row();
    end
    cursor_col_model++;
    return 1'b0;
  endfunction

  // expected result of one operation, updating the shadow state
  function automatic tccw_pkg::out_t predict_console(tccw_pkg::in_t item);
    tccw_pkg::out_t res;
    res = '0;
    if (item.opcode == tccw_pkg::OP_READ) begin
      if (item.read_column < SCREEN_COLS && item.read_row < SCREEN_ROWS)
        res.cell_value = screen_model[item.read_row * SCREEN_COLS + item.read_column];
    end else if (item.char_code == tccw_pkg::CHAR_NEWLINE) begin
      cursor_col_model = 0;
      res.scrolled = model_next_row();
    end else if (item.char_code == tccw_pkg::CHAR_TAB) begin
      for (int k = 0; k < TAB_WIDTH; k++)
        if (model_put(tccw_pkg::CHAR_SPACE)) res.scrolled = 1'b1;
    end else begin
      res.scrolled = model_put(item.char_code);
    end
    res.cursor_row    = cursor_row_model[4:0];
    res.cursor_column = cursor_col_model[6:0];
    return res;
  endfunction

  function automatic tccw_pkg::in_t make_put(logic [7:0] ch);
    tccw_pkg::in_t item;
    item.opcode      = tccw_pkg::OP_PUT;
    item.char_code   = ch;
    item.read_column = 7'($urandom);
    item.read_row    = 5'($urandom);
    return item;
  endfunction

  function automatic tccw_pkg::in_t make_read(int row, int col);
    tccw_pkg::in_t item;
    item.opcode      = tccw_pkg::OP_READ;
    item.char_code   = 8'($urandom);
    item.read_column = col[6:0];
    item.read_row    = row[4:0];
    return item;
  endfunction

  // any byte that is not newline or tab
  function automatic logic [7:0] random_glyph();
    logic [7:0] ch;
    do ch = 8'($urandom_range(0, 255));
    while (ch == tccw_pkg::CHAR_TAB || ch == tccw_pkg::CHAR_NEWLINE);
    return ch;
  endfunction

  // mix of reads, plain bytes, newlines and tabs
  function automatic tccw_pkg::in_t random_console_op();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) return make_read($urandom_range(0, 31), $urandom_range(0, 127));
    if (pick < 20) return make_read(cursor_row_model, $urandom_range(0, SCREEN_COLS - 1));
    if (pick < 35)
      return make_read($urandom_range(0, SCREEN_ROWS - 1), $urandom_range(0, SCREEN_COLS - 1));
    if (pick < 38) return make_put(tccw_pkg::CHAR_NEWLINE);
    if (pick < 43) return make_put(tccw_pkg::CHAR_TAB);
    return make_put(8'($urandom_range(0, 255)));
  endfunction

  // one input transfer; start stays high afterwards until someone lowers it
  task automatic send_item(input tccw_pkg::in_t item);
    int gap;
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk);
    while (busy);
    console_results_due.push_back(predict_console(item));
  endtask

  // stop sending and wait for every pending result and an idle block
  task automatic drain_results();
    int waited;
    waited = 0;
    start <= 1'b0;
    while ((console_results_due.size() != 0 || busy) && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  task automatic write_color(input logic [7:0] color);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= color;
    @(posedge clk);
    cfg_we      <= 1'b0;
    color_model = color;
  endtask

  // result check against the oldest pending expectation
  always @(posedge clk) begin
    tccw_pkg::out_t want;
    if (rst_n && out_valid) begin
      if (console_results_due.size() == 0) begin
        $error("result with no transfer pending: %p", out_data);
        fail_count++;
      end else begin
        want = console_results_due.pop_front();
        if (out_data.cell_value !== want.cell_value) begin
          $error("cell_value: expected %h, got %h", want.cell_value, out_data.cell_value);
          fail_count++;
        end
        if (out_data.cursor_row !== want.cursor_row) begin
          $error("cursor_row: expected %0d, got %0d", want.cursor_row, out_data.cursor_row);
          fail_count++;
        end
        if (out_data.cursor_column !== want.cursor_column) begin
          $error("cursor_column: expected %0d, got %0d",
                 want.cursor_column, out_data.cursor_column);
          fail_count++;
        end
        if (out_data.scrolled !== want.scrolled) begin
          $error("scrolled: expected %0d, got %0d", want.scrolled, out_data.scrolled);
          fail_count++;
        end
      end
    end
  end

  // cleared screen in the reset color, plus reads outside the screen
  task automatic test_reset_screen();
    send_item(make_read(0, 0));
    send_item(make_read(SCREEN_ROWS - 1, SCREEN_COLS - 1));
    send_item(make_read(12, 40));
    send_item(make_read(0, SCREEN_COLS));
    send_item(make_read(SCREEN_ROWS, 0));
    send_item(make_read(SCREEN_ROWS - 1, SCREEN_COLS));
    send_item(make_read(31, 127));
  endtask

  // plain bytes at both color extremes, tab, newline, then read back
  task automatic test_put_and_read();
    write_color(8'h00);
    send_item(make_put(8'h41));
    send_item(make_put(8'h00));
    write_color(8'hFF);
    send_item(make_put(8'hFF));
    send_item(make_put(tccw_pkg::CHAR_TAB));
    send_item(make_put(8'h7A));
    send_item(make_put(tccw_pkg::CHAR_NEWLINE));
    send_item(make_put(tccw_pkg::CHAR_NEWLINE));
    for (int c = 0; c < 8; c++) send_item(make_read(0, c));
  endtask

  // scroll by newline, wrap on the last row, tabs straddling the right edge
  task automatic test_bottom_edge();
    write_color(8'($urandom_range(1, 254)));
    while (cursor_row_model != SCREEN_ROWS - 1) send_item(make_put(tccw_pkg::CHAR_NEWLINE));
    send_item(make_put(tccw_pkg::CHAR_NEWLINE));
    while (cursor_col_model != SCREEN_COLS - 1) send_item(make_put(random_glyph()));
    send_item(make_put(random_glyph()));
    for (int k = 1; k <= TAB_WIDTH; k++) begin
      while (cursor_col_model != SCREEN_COLS - k) send_item(make_put(random_glyph()));
      send_item(make_put(tccw_pkg::CHAR_TAB));
    end
    for (int i = 0; i < 16; i++)
      send_item(make_read(SCREEN_ROWS - 1 - (i % 2), $urandom_range(0, SCREEN_COLS - 1)));
  endtask

  // random phases, each under its own color
  task automatic test_random_traffic();
    logic [7:0] color;
    for (int p = 0; p < 5; p++) begin
      color = (p == 2) ? 8'h00 : (p == 3) ? 8'hFF : 8'($urandom_range(0, 255));
      write_color(color);
      idle_enabled = (p != 2) && (p != 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == PHASE_ITEMS / 2) drain_results();
        send_item(random_console_op());
      end
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    idle_enabled = 1'b1;
    color_model  = tccw_pkg::RESET_COLOR;
    cursor_row_model = 0;
    cursor_col_model = 0;
    for (int i = 0; i < SCREEN_CELLS; i++) screen_model[i] = tccw_pkg::RESET_CELL;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_screen();
    test_put_and_read();
    test_bottom_edge();
    test_random_traffic();

    // wait out the last results
    drain_results();
    repeat (16) @(posedge clk);
    if (console_results_due.size() != 0) begin
      $error("%0d results never arrived", console_results_due.size());
    end
    if (fail_count == 0 && console_results_due.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
